>>> hw/rtl/kia_pkg.sv
`default_nettype none

package kia_pkg;

	// table size default
	localparam int TABLE_DEPTH_DEF = 256;

	// configuration port geometry
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POOL_NETWORK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_PREFIX    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_ADDRESS = 2'd2;

	// field widths
	localparam int KEY_W    = 64;
	localparam int ADDR_W   = 32;
	localparam int PREFIX_W = 5;
	localparam int STATUS_W = 2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_EXISTING  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NEW       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SEARCH,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic search;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic scan_done;
		logic search_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/kia_ifs.sv
`default_nettype none

// request channel: client key
interface kia_key_if;
	logic        valid;
	logic        ready;
	logic [63:0] key_word0;
	logic [63:0] key_word1;
	logic [63:0] key_word2;
	logic [63:0] key_word3;

	modport source (
		output valid, key_word0, key_word1, key_word2, key_word3,
		input  ready
	);
	modport sink (
		input  valid, key_word0, key_word1, key_word2, key_word3,
		output ready
	);
endinterface

// response channel: address and status
interface kia_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] assigned_address;
	logic [1:0]  status;

	modport source (
		output valid, assigned_address, status,
		input  ready
	);
	modport sink (
		input  valid, assigned_address, status,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/kia_ctrl.sv
`default_nettype none

module kia_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  kia_pkg::sts_t    sts,
	output kia_pkg::cmd_t    cmd
);
	import kia_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = S_DONE;
				end else if (sts.scan_done) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (sts.search_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// at most one datapath phase is commanded per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.scan, cmd.search, cmd.emit}))
		else $error("kia_ctrl: more than one command active");

	// a transaction is taken only from idle and always starts a table walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_SCAN))
		else $error("kia_ctrl: accepted request did not start a scan");

	// a result is emitted only after a hit or a finished search
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> ($past(sts.hit) || $past(sts.search_done) || $past(state_q == S_DONE)))
		else $error("kia_ctrl: result emitted without a decision");

endmodule

`default_nettype wire

>>> hw/rtl/kia_dp.sv
`default_nettype none

module kia_dp #(
	parameter int TABLE_DEPTH = kia_pkg::TABLE_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [kia_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [kia_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire  [kia_pkg::KEY_W-1:0]      key_word0,
	input  wire  [kia_pkg::KEY_W-1:0]      key_word1,
	input  wire  [kia_pkg::KEY_W-1:0]      key_word2,
	input  wire  [kia_pkg::KEY_W-1:0]      key_word3,
	input  kia_pkg::cmd_t                  cmd,
	output kia_pkg::sts_t                  sts,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [kia_pkg::ADDR_W-1:0]     out_address,
	output logic [kia_pkg::STATUS_W-1:0]   out_status
);
	import kia_pkg::*;

	localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	// offsets 1..TABLE_DEPTH+2 always hold a free candidate
	localparam int BM  = TABLE_DEPTH + 3;
	localparam int OW  = $clog2(BM);
	localparam int KW  = 4 * KEY_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// configuration registers
	logic [ADDR_W-1:0]   network_q;
	logic [PREFIX_W-1:0] prefix_q;
	logic [ADDR_W-1:0]   server_q;

	// binding table
	logic [KW-1:0]     key_mem  [TABLE_DEPTH];
	logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
	logic [CW-1:0]     fill_q;

	// walk state
	logic [KW-1:0]     key_q;
	logic [CW-1:0]     idx_q;
	logic              valid_s1;
	logic [KW-1:0]     key_rd_s1;
	logic [ADDR_W-1:0] addr_rd_s1;
	logic [BM-1:0]     used_q;
	logic [OW-1:0]     off_q;

	// pending result
	logic [ADDR_W-1:0]   res_addr_q;
	logic [STATUS_W-1:0] res_status_q;

	logic [ADDR_W-1:0] hmask;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] srv_off;
	logic [ADDR_W-1:0] ent_off;
	logic [ADDR_W-1:0] cand;
	logic              rd_en;
	logic              hit;
	logic              past_end;
	logic              cand_free;
	logic              tbl_full;
	logic              wr_en;

	// pool geometry
	assign hmask   = {ADDR_W{1'b1}} >> prefix_q;
	assign base    = network_q & ~hmask;
	assign srv_off = server_q - base;
	assign ent_off = addr_rd_s1 - base;
	assign cand    = base + ADDR_W'(off_q);

	// scan and search decisions
	assign rd_en     = cmd.scan && (idx_q < fill_q) && !hit;
	assign hit       = cmd.scan && valid_s1 && (key_rd_s1 == key_q);
	assign past_end  = ADDR_W'(off_q) >= hmask;
	assign cand_free = !used_q[off_q];
	assign tbl_full  = (fill_q == DEPTH_C);
	assign wr_en     = cmd.search && !past_end && cand_free && !tbl_full;

	assign sts.hit         = hit;
	assign sts.scan_done   = (idx_q == fill_q) && !valid_s1;
	assign sts.search_done = cmd.search && (past_end || cand_free);
	assign sts.out_free    = !out_valid || out_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			network_q <= '0;
			prefix_q  <= PREFIX_W'(24);
			server_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POOL_NETWORK:   network_q <= cfg_data[ADDR_W-1:0];
				REG_POOL_PREFIX:    prefix_q  <= cfg_data[PREFIX_W-1:0];
				REG_SERVER_ADDRESS: server_q  <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// table memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[fill_q[IW-1:0]]  <= key_q;
			addr_mem[fill_q[IW-1:0]] <= cand;
		end
		if (rd_en) begin
			key_rd_s1  <= key_mem[idx_q[IW-1:0]];
			addr_rd_s1 <= addr_mem[idx_q[IW-1:0]];
		end
	end

	// latched request key
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= {key_word3, key_word2, key_word1, key_word0};
		end
	end

	// fill count and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			off_q    <= '0;
		end else begin
			valid_s1 <= rd_en;
			if (cmd.start) begin
				idx_q <= '0;
				off_q <= OW'(1);
			end else if (rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.search && !past_end && !cand_free) begin
				off_q <= off_q + OW'(1);
			end
			if (wr_en) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// occupancy map of the low pool offsets
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			used_q <= (srv_off < ADDR_W'(BM)) ? (BM'(1) << srv_off[OW-1:0]) : '0;
		end else if (cmd.scan && valid_s1 && (ent_off < ADDR_W'(BM))) begin
			used_q[ent_off[OW-1:0]] <= 1'b1;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (hit) begin
			res_addr_q   <= addr_rd_s1;
			res_status_q <= ST_EXISTING;
		end else if (cmd.search) begin
			if (past_end) begin
				res_addr_q   <= '0;
				res_status_q <= ST_EXHAUSTED;
			end else if (cand_free && tbl_full) begin
				res_addr_q   <= '0;
				res_status_q <= ST_FULL;
			end else if (cand_free) begin
				res_addr_q   <= cand;
				res_status_q <= ST_NEW;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_address <= res_addr_q;
			out_status  <= res_status_q;
		end
	end

	// fill count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("kia_dp: fill count beyond table depth");

	// error results carry a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_status == ST_EXHAUSTED || out_status == ST_FULL))
		|-> (out_address == '0))
		else $error("kia_dp: error result with nonzero address");

	// the table grows only by a new binding, one slot at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> ($past(wr_en) && fill_q == $past(fill_q) + CW'(1)))
		else $error("kia_dp: fill count changed without a table write");

	// the search never runs off the occupancy map
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search |-> (32'(off_q) < 32'(BM)))
		else $error("kia_dp: candidate offset beyond occupancy map");

endmodule

`default_nettype wire

>>> hw/rtl/keyed_ip_address_allocator.sv
// keyed ip address allocator
// operation: a request walks the bound slots through the table memory read port; on a key match
//   the stored address is returned, otherwise candidate offsets from 1 upward (at most up to
//   TABLE_DEPTH+2) are tested against the occupancy map until a free one or the pool end is found
// requests: one at a time, taken only while idle; the next is taken once the result is registered
// reset: arst_n resets the fill count, control and configuration; table memories need no clearing pass
`default_nettype none

module keyed_ip_address_allocator #(
	parameter int TABLE_DEPTH = kia_pkg::TABLE_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [kia_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [kia_pkg::CFG_DATA_W-1:0] cfg_data,
	kia_key_if.sink                        req,
	kia_res_if.source                      rsp
);
	import kia_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// control sequencer
	kia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, search and result datapath
	kia_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.key_word0   (req.key_word0),
		.key_word1   (req.key_word1),
		.key_word2   (req.key_word2),
		.key_word3   (req.key_word3),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_address (rsp.assigned_address),
		.out_status  (rsp.status)
	);

endmodule

`default_nettype wire
